/* rtl/btg_pkg.sv */
// ----------------------------------------------------------------------------
// btg_pkg
// Shared types and codes of the button tap gesture classifier.
// ----------------------------------------------------------------------------
package btg_pkg;

    localparam int TimeWidth = 32;
    localparam int LenWidth  = 16;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;
    localparam int InDataWidth   = 40;
    localparam int OutDataWidth  = 56;
    localparam int OutUserWidth  = 2;

    // Tap phase codes
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_ONE    = 2'd1;
    localparam logic [1:0] PHASE_DOUBLE = 2'd2;
    localparam logic [1:0] PHASE_LONG   = 2'd3;

    // Tap kind codes
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_DOUBLE = 2'd2;
    localparam logic [1:0] KIND_LONG   = 2'd3;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_LONG_PRESS_MS     = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_DOUBLE_TAP_GAP_MS = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_ACTIVE_LOW        = 2'd2;

    localparam logic [LenWidth-1:0] LONG_PRESS_RESET = 16'd500;
    localparam logic [LenWidth-1:0] DOUBLE_GAP_RESET = 16'd150;

    typedef struct packed {
        logic [1:0]           phase;
        logic                 was_active;
        logic [TimeWidth-1:0] start_time;
        logic [TimeWidth-1:0] end_time;
        logic [LenWidth-1:0]  first_len;
        logic [LenWidth-1:0]  gap_len;
        logic [LenWidth-1:0]  second_len;
    } btg_state_t;

    typedef struct packed {
        logic [LenWidth-1:0] long_press_ms;
        logic [LenWidth-1:0] double_tap_gap_ms;
        logic                active_low;
    } btg_cfg_t;

endpackage

/* rtl/btg_classify.sv */
// ----------------------------------------------------------------------------
// btg_classify
// Next-state and tap-kind logic for one poll of the button.
// ----------------------------------------------------------------------------
module btg_classify (
    input  btg_pkg::btg_cfg_t                 cfg,
    input  btg_pkg::btg_state_t               state,
    input  logic                              pin_level,
    input  logic [btg_pkg::TimeWidth-1:0]     now_ms,
    output btg_pkg::btg_state_t               state_next,
    output logic [1:0]                        tap_kind
);

    logic                          pressed;
    logic [btg_pkg::TimeWidth-1:0] held_time;
    logic [btg_pkg::TimeWidth-1:0] idle_time;
    logic [btg_pkg::TimeWidth-1:0] press_time;
    logic [btg_pkg::TimeWidth-1:0] release_time;
    logic                          long_hit;
    logic                          gap_hit;

    assign pressed      = cfg.active_low ? ~pin_level : pin_level;
    assign held_time    = now_ms - state.start_time;
    assign idle_time    = now_ms - state.end_time;
    assign press_time   = state.end_time - state.start_time;
    // length of the press that ends with this poll
    assign release_time = now_ms - state.start_time;
    assign long_hit = held_time >= {{(btg_pkg::TimeWidth-btg_pkg::LenWidth){1'b0}},
                                    cfg.long_press_ms};
    assign gap_hit  = idle_time >= {{(btg_pkg::TimeWidth-btg_pkg::LenWidth){1'b0}},
                                    cfg.double_tap_gap_ms};

    always_comb
    begin
        state_next = state;
        tap_kind   = btg_pkg::KIND_NONE;
        if (pressed && !state.was_active)
        begin
            if (state.phase == btg_pkg::PHASE_ONE)
            begin
                tap_kind              = btg_pkg::KIND_DOUBLE;
                state_next.phase      = btg_pkg::PHASE_DOUBLE;
                state_next.first_len  = press_time[btg_pkg::LenWidth-1:0];
                state_next.start_time = now_ms;
                state_next.gap_len    = idle_time[btg_pkg::LenWidth-1:0];
                state_next.was_active = 1'b1;
            end
            else if (state.phase == btg_pkg::PHASE_IDLE)
            begin
                state_next.phase      = btg_pkg::PHASE_ONE;
                state_next.start_time = now_ms;
                state_next.was_active = 1'b1;
            end
        end
        else if (pressed && state.was_active)
        begin
            if (state.phase == btg_pkg::PHASE_ONE && long_hit)
            begin
                tap_kind         = btg_pkg::KIND_LONG;
                state_next.phase = btg_pkg::PHASE_LONG;
            end
        end
        else if (!pressed && state.was_active)
        begin
            state_next.end_time   = now_ms;
            state_next.was_active = 1'b0;
            if (state.phase == btg_pkg::PHASE_DOUBLE)
            begin
                state_next.phase      = btg_pkg::PHASE_IDLE;
                state_next.second_len = release_time[btg_pkg::LenWidth-1:0];
            end
            else if (state.phase == btg_pkg::PHASE_LONG)
            begin
                state_next.phase      = btg_pkg::PHASE_IDLE;
                state_next.first_len  = release_time[btg_pkg::LenWidth-1:0];
                state_next.gap_len    = '0;
                state_next.second_len = '0;
            end
        end
        else
        begin
            if (state.phase == btg_pkg::PHASE_ONE && gap_hit)
            begin
                tap_kind              = btg_pkg::KIND_SINGLE;
                state_next.phase      = btg_pkg::PHASE_IDLE;
                state_next.first_len  = press_time[btg_pkg::LenWidth-1:0];
                state_next.gap_len    = '0;
                state_next.second_len = '0;
            end
        end
    end

endmodule

/* rtl/button_tap_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// button_tap_gesture_classifier
// Classifies button polls as single tap, double tap or long press.
// ----------------------------------------------------------------------------
// A poll accepted by the block sits in the input register. When the result
// register is free or being emptied, the tap state and the result register
// update together from it, and its result stands on the master side in the
// result register. A new poll is taken every cycle while the master side
// keeps up. The rate is set by the update of the tap state, whose next value
// depends on the previous poll. Every poll yields exactly one result.
// Configuration writes are meant for an idle block.
// long_press_ms and double_tap_gap_ms are compared with >= against wrapping
// 32-bit time differences.
module button_tap_gesture_classifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [btg_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [btg_pkg::CfgDataWidth-1:0]     cfg_data,
    // poll input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    input  logic [btg_pkg::InDataWidth-1:0]      s_tdata,
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] data_ready, [16:1] first_press_ms, [32:17] tap_gap_ms,
    // [48:33] second_press_ms, [55:49] zero
    output logic [btg_pkg::OutDataWidth-1:0]     m_tdata,
    // [1:0] tap_kind
    output logic [btg_pkg::OutUserWidth-1:0]     m_tuser
);

    btg_pkg::btg_cfg_t             cfg_reg;
    btg_pkg::btg_state_t           state_reg;
    btg_pkg::btg_state_t           state_next;
    logic [1:0]                    kind_next;

    logic                          in_valid_reg;
    logic                          in_level_reg;
    logic [btg_pkg::TimeWidth-1:0] in_now_reg;

    logic                          out_valid_reg;
    logic [1:0]                    out_kind_reg;
    logic                          out_ready_flag_reg;
    logic [btg_pkg::LenWidth-1:0]  out_first_reg;
    logic [btg_pkg::LenWidth-1:0]  out_gap_reg;
    logic [btg_pkg::LenWidth-1:0]  out_second_reg;

    logic                          advance;

    // advance the poll when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms     <= btg_pkg::LONG_PRESS_RESET;
            cfg_reg.double_tap_gap_ms <= btg_pkg::DOUBLE_GAP_RESET;
            cfg_reg.active_low        <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                btg_pkg::REG_LONG_PRESS_MS:     cfg_reg.long_press_ms     <= cfg_data;
                btg_pkg::REG_DOUBLE_TAP_GAP_MS: cfg_reg.double_tap_gap_ms <= cfg_data;
                btg_pkg::REG_ACTIVE_LOW:        cfg_reg.active_low        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[btg_pkg::TimeWidth:1];
        end
    end

    btg_classify u_classify (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .pin_level  (in_level_reg),
        .now_ms     (in_now_reg),
        .state_next (state_next),
        .tap_kind   (kind_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg       <= kind_next;
            out_ready_flag_reg <= (state_next.phase == btg_pkg::PHASE_IDLE);
            out_first_reg      <= state_next.first_len;
            out_gap_reg        <= state_next.gap_len;
            out_second_reg     <= state_next.second_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_second_reg, out_gap_reg, out_first_reg, out_ready_flag_reg};

    // A double tap leaves the state in the double phase
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && kind_next == btg_pkg::KIND_DOUBLE |=> state_reg.phase == btg_pkg::PHASE_DOUBLE)
        else $error("double tap did not enter double phase");

    // A long press leaves the state in the long phase
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && kind_next == btg_pkg::KIND_LONG |=> state_reg.phase == btg_pkg::PHASE_LONG)
        else $error("long press did not enter long phase");

    // The reported ready flag matches the phase left by the same poll
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_ready_flag_reg == (state_reg.phase == btg_pkg::PHASE_IDLE))
        else $error("data ready flag out of step with tap phase");

    // Double and long phases only exist while the button is held
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == btg_pkg::PHASE_DOUBLE || state_reg.phase == btg_pkg::PHASE_LONG
        |-> state_reg.was_active)
        else $error("double or long phase with button released");

endmodule

/* tb/tap_tb_pkg.sv */
// ----------------------------------------------------------------------------
// tap_tb_pkg
// Tap gesture predictor and result checker for the button tap classifier
// testbench. Each accepted poll advances a private copy of the tap state
// and queues the result the block has to produce for it.
// ----------------------------------------------------------------------------
package tap_tb_pkg;

    import btg_pkg::*;

    typedef struct packed {
        logic [1:0]          kind;
        logic                ready;
        logic [LenWidth-1:0] first_len;
        logic [LenWidth-1:0] gap_len;
        logic [LenWidth-1:0] second_len;
    } tap_result_t;

    class tap_gesture_checker;

        logic [LenWidth-1:0]  long_ms  = LONG_PRESS_RESET;
        logic [LenWidth-1:0]  gap_ms   = DOUBLE_GAP_RESET;
        logic                 act_low  = 1'b1;

        logic [1:0]           phase    = PHASE_IDLE;
        logic                 held     = 1'b0;
        logic [TimeWidth-1:0] t_start  = '0;
        logic [TimeWidth-1:0] t_end    = '0;
        logic [LenWidth-1:0]  first_len  = '0;
        logic [LenWidth-1:0]  gap_len    = '0;
        logic [LenWidth-1:0]  second_len = '0;

        tap_result_t expected_taps[$];
        int          mismatches = 0;

        function void write_reg(logic [CfgIndexWidth-1:0] idx,
                                logic [CfgDataWidth-1:0] val);
            case (idx)
                REG_LONG_PRESS_MS:     long_ms = val;
                REG_DOUBLE_TAP_GAP_MS: gap_ms  = val;
                REG_ACTIVE_LOW:        act_low = val[0];
                default: ;
            endcase
        endfunction

        function void note_poll(logic pin, logic [TimeWidth-1:0] now_ms);
            logic                 pressed;
            logic [1:0]           kind;
            logic [TimeWidth-1:0] held_for;
            logic [TimeWidth-1:0] idle_for;
            tap_result_t          res;
            pressed  = act_low ? ~pin : pin;
            kind     = KIND_NONE;
            held_for = now_ms - t_start;
            idle_for = now_ms - t_end;
            if (pressed && !held) begin
                if (phase == PHASE_ONE) begin
                    kind      = KIND_DOUBLE;
                    phase     = PHASE_DOUBLE;
                    first_len = LenWidth'(t_end - t_start);
                    gap_len   = LenWidth'(now_ms - t_end);
                    t_start   = now_ms;
                    held      = 1'b1;
                end
                else if (phase == PHASE_IDLE) begin
                    phase   = PHASE_ONE;
                    t_start = now_ms;
                    held    = 1'b1;
                end
                // rising edge in double or long phase: leave everything as is
            end
            else if (pressed) begin
                if (phase == PHASE_ONE && held_for >= TimeWidth'(long_ms)) begin
                    kind  = KIND_LONG;
                    phase = PHASE_LONG;
                end
            end
            else if (held) begin
                t_end = now_ms;
                held  = 1'b0;
                if (phase == PHASE_DOUBLE) begin
                    phase      = PHASE_IDLE;
                    second_len = LenWidth'(t_end - t_start);
                end
                else if (phase == PHASE_LONG) begin
                    phase      = PHASE_IDLE;
                    first_len  = LenWidth'(t_end - t_start);
                    gap_len    = '0;
                    second_len = '0;
                end
            end
            else if (phase == PHASE_ONE && idle_for >= TimeWidth'(gap_ms)) begin
                kind       = KIND_SINGLE;
                phase      = PHASE_IDLE;
                first_len  = LenWidth'(t_end - t_start);
                gap_len    = '0;
                second_len = '0;
            end
            res.kind       = kind;
            res.ready      = (phase == PHASE_IDLE);
            res.first_len  = first_len;
            res.gap_len    = gap_len;
            res.second_len = second_len;
            expected_taps.push_back(res);
        endfunction

        function void check_result(logic [OutDataWidth-1:0] data,
                                   logic [OutUserWidth-1:0] user);
            tap_result_t want;
            tap_result_t got;
            got.kind       = user[1:0];
            got.ready      = data[0];
            got.first_len  = data[16:1];
            got.gap_len    = data[32:17];
            got.second_len = data[48:33];
            if (expected_taps.size() == 0) begin
                if (mismatches < 10)
                    $display("tb_top: unexpected result kind=%0d ready=%0b first=%0d gap=%0d second=%0d",
                             got.kind, got.ready, got.first_len, got.gap_len, got.second_len);
                mismatches++;
            end
            else begin
                want = expected_taps.pop_front();
                if (got.kind !== want.kind || got.ready !== want.ready ||
                    got.first_len !== want.first_len || got.gap_len !== want.gap_len ||
                    got.second_len !== want.second_len) begin
                    if (mismatches < 10)
                        $display({"tb_top: mismatch expected kind=%0d ready=%0b first=%0d ",
                                  "gap=%0d second=%0d, got kind=%0d ready=%0b first=%0d ",
                                  "gap=%0d second=%0d"},
                                 want.kind, want.ready, want.first_len, want.gap_len,
                                 want.second_len, got.kind, got.ready, got.first_len,
                                 got.gap_len, got.second_len);
                    mismatches++;
                end
            end
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the button tap gesture classifier. Directed polls cover long
// press, single and double tap, length truncation and time wrap; random
// press and release gestures with noise then run under several threshold
// and polarity settings, with both stream sides idling at random in some runs.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import btg_pkg::*;
    import tap_tb_pkg::*;

    localparam int CycleLimit = 200_000;
    localparam logic DOWN = 1'b1;
    localparam logic UP   = 1'b0;
    localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;
    logic                     s_tvalid;
    logic                     s_tready;
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    logic [InDataWidth-1:0]   s_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // [0] data_ready, [16:1] first_press_ms, [32:17] tap_gap_ms,
    // [48:33] second_press_ms, [55:49] zero
    logic [OutDataWidth-1:0]  m_tdata;
    // [1:0] tap_kind
    logic [OutUserWidth-1:0]  m_tuser;

    tap_gesture_checker board;
    logic [TimeWidth-1:0] clock_ms;
    int unsigned          src_idle_pct;
    int unsigned          sink_idle_pct;
    int                   sent;
    int                   cycles;

    button_tap_gesture_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // check results before noting polls so a stray result never meets a fresh entry
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                board.note_poll(s_tdata[0], s_tdata[32:1]);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_poll(input logic pin, input logic [TimeWidth-1:0] t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, t, pin};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        @(negedge clk);
    endtask

    task automatic poll(input logic pressed);
        send_poll(board.act_low ? ~pressed : pressed, clock_ms);
    endtask

    task automatic poll_at(input logic pressed, input logic [TimeWidth-1:0] t);
        clock_ms = t;
        poll(pressed);
    endtask

    // poll repeatedly in one button state until dur milliseconds have passed
    task automatic hold(input logic pressed, input int unsigned dur,
                        input int unsigned step_max);
        logic [TimeWidth-1:0] t0;
        t0 = clock_ms;
        do
        begin
            poll(pressed);
            clock_ms += $urandom_range(step_max);
        end
        while (clock_ms - t0 < dur);
    endtask

    task automatic gesture(input int unsigned step_max);
        int unsigned lp;
        int unsigned gp;
        lp = board.long_ms;
        gp = board.gap_ms;
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(6, 1))
            begin
                if ($urandom_range(3) == 0)
                    clock_ms += $urandom;
                else
                    clock_ms += $urandom_range(step_max * 4);
                poll(1'($urandom_range(1)));
            end
        end
        else
        begin
            // one to three presses with durations around the thresholds
            repeat ($urandom_range(3, 1))
            begin
                hold(DOWN, $urandom_range(lp + lp / 2 + 1), step_max);
                hold(UP, $urandom_range(gp + gp / 2 + 1), step_max);
            end
            hold(UP, $urandom_range(gp * 2 + 1, gp), step_max);
        end
    endtask

    task automatic random_polls(input int target, input int unsigned step_max);
        int first;
        first = sent;
        clock_ms = $urandom;
        while (sent - first < target)
            gesture(step_max);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // drain every outstanding result, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.expected_taps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic directed_polls();
        // long press, then release
        poll_at(UP, 32'd0);
        poll_at(DOWN, 32'd100);
        poll_at(DOWN, 32'd599);
        poll_at(DOWN, 32'd600);
        poll_at(DOWN, 32'd700);
        poll_at(UP, 32'd710);
        // single tap, declared exactly at the gap threshold
        poll_at(DOWN, 32'd1000);
        poll_at(UP, 32'd1050);
        poll_at(UP, 32'd1199);
        poll_at(UP, 32'd1200);
        // double tap
        poll_at(DOWN, 32'd2000);
        poll_at(UP, 32'd2040);
        poll_at(DOWN, 32'd2100);
        poll_at(DOWN, 32'd2130);
        poll_at(UP, 32'd2160);
        // long press longer than 16 bits of milliseconds
        poll_at(DOWN, 32'd5000);
        poll_at(DOWN, 32'd75000);
        poll_at(UP, 32'd75001);
        // double tap across the time wrap
        poll_at(DOWN, 32'hFFFF_FF80);
        poll_at(UP, 32'hFFFF_FFFF);
        poll_at(DOWN, 32'h0000_0010);
        poll_at(UP, 32'h0000_0040);
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        clock_ms      = '0;
        sent          = 0;
        cycles        = 0;
        src_idle_pct  = 6;
        sink_idle_pct = 73;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_polls();
        settle();

        write_reg(REG_LONG_PRESS_MS, 16'd40);
        write_reg(REG_DOUBLE_TAP_GAP_MS, 16'd25);
        write_reg(REG_ACTIVE_LOW, 16'd0);
        random_polls(600, 6);
        settle();

        src_idle_pct  = 73;
        sink_idle_pct = 6;
        write_reg(REG_LONG_PRESS_MS, 16'd30);
        write_reg(REG_DOUBLE_TAP_GAP_MS, 16'd20);
        write_reg(REG_ACTIVE_LOW, 16'd1);
        random_polls(600, 5);
        settle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(REG_LONG_PRESS_MS, 16'd0);
        write_reg(REG_DOUBLE_TAP_GAP_MS, 16'd0);
        random_polls(150, 3);
        settle();

        write_reg(REG_LONG_PRESS_MS, 16'hFFFF);
        write_reg(REG_DOUBLE_TAP_GAP_MS, 16'hFFFF);
        random_polls(150, 5000);
        settle();

        write_reg(REG_LONG_PRESS_MS, 16'd60);
        write_reg(REG_DOUBLE_TAP_GAP_MS, 16'd35);
        write_reg(REG_ACTIVE_LOW, 16'hFFFE);
        write_reg(REG_UNUSED, 16'($urandom));
        random_polls(300, 8);
        settle();

        repeat (8) @(negedge clk);
        if (board.mismatches == 0 && board.expected_taps.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
